>>> rtl/lksc_pkg.sv
// shared types, constants and helpers for the lru keyed slot cache
// no dependencies
package lksc_pkg;

  localparam int KEY_W    = 53;
  localparam int STAMP_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int HANDLE_W = 32;
  localparam int LAYER_W  = 8;
  localparam int RQ4_W    = 16;
  localparam int RAD_W    = 13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_done;
  } dp_status_t;

  // round q4 radius half up to an integer
  function automatic logic [RAD_W-1:0] round_radius(input logic [RQ4_W-1:0] r);
    logic [RQ4_W:0] s;
    s = {1'b0, r} + (RQ4_W+1)'(8);
    return s[RQ4_W:4];
  endfunction

endpackage

>>> rtl/lru_keyed_slot_cache_unit.sv
// top level of the lru keyed slot cache: controller plus datapath
// depends on lksc_pkg, lksc_ctrl, lksc_dp
// A request is taken when start is high and busy is low. The block then reads
// the filled slots one per cycle from a single-read-port store, comparing keys
// and tracking the oldest stamp, and writes the chosen slot back. Busy stays
// high through the scan and the write-back, and an early hit ends the scan
// sooner. The result word is registered from the write-back and is shown for
// exactly one cycle with done high and cannot be stalled. A new request may
// be started in that same cycle, but not while busy is high.
module lru_keyed_slot_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lksc_pkg::HANDLE_W-1:0] key_handle,
  input  logic [lksc_pkg::LAYER_W-1:0]  layer_count,
  input  logic [lksc_pkg::RQ4_W-1:0]    radius_q4,
  output logic                          done,
  output logic                          hit,
  output logic [lksc_pkg::SLOT_W-1:0]   slot,
  output logic                          evicted
);
  import lksc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lksc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  lksc_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .key_handle (key_handle),
    .layer_count(layer_count),
    .radius_q4  (radius_q4),
    .done       (done),
    .hit        (hit),
    .slot       (slot),
    .evicted    (evicted)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a request in flight");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> !evicted)
    else $error("eviction reported on a hit");

endmodule

>>> rtl/lksc_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module lksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/lksc_ctrl.sv
// controller state machine for the lru keyed slot cache
// depends on lksc_pkg
module lksc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  lksc_pkg::dp_status_t status,
  output lksc_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import lksc_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match || status.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> rtl/lksc_dp.sv
// datapath: key register, slot store scan, lru tracking and result registers
// depends on lksc_pkg and lksc_ram
module lksc_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lksc_pkg::ctrl_cmd_t             cmd,
  output lksc_pkg::dp_status_t            status,
  input  logic [lksc_pkg::HANDLE_W-1:0]  key_handle,
  input  logic [lksc_pkg::LAYER_W-1:0]   layer_count,
  input  logic [lksc_pkg::RQ4_W-1:0]     radius_q4,
  output logic                           done,
  output logic                           hit,
  output logic [lksc_pkg::SLOT_W-1:0]    slot,
  output logic                           evicted
);
  import lksc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = KEY_W + STAMP_W;

  logic [KEY_W-1:0]   key_reg;
  logic [CW-1:0]      rd_ptr;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  logic               hit_r;
  logic [AW-1:0]      hit_idx;
  logic [AW-1:0]      best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic               best_valid;
  logic [CW-1:0]      filled_count;
  logic [STAMP_W-1:0] use_clock;

  logic [RW-1:0]      rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_more;
  logic               full;
  logic               re;
  logic [AW-1:0]      pick;
  logic [STAMP_W-1:0] stamp_new;

  assign rd_key    = rdata[RW-1:STAMP_W];
  assign rd_stamp  = rdata[STAMP_W-1:0];
  assign rd_more   = (rd_ptr < filled_count);
  assign full      = (filled_count == CW'(ENTRIES));
  assign re        = cmd.scan && rd_more;
  assign stamp_new = use_clock + STAMP_W'(1);
  assign pick      = hit_r ? hit_idx : (full ? best_idx : filled_count[AW-1:0]);

  assign status.match     = pend && (rd_key == key_reg);
  assign status.scan_done = !pend && !rd_more;

  lksc_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(pick),
    .wdata({key_reg, stamp_new}),
    .re   (re),
    .raddr(rd_ptr[AW-1:0]),
    .rdata(rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_count <= '0;
      use_clock    <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= rd_more;
      end
      if (cmd.update) begin
        use_clock <= stamp_new;
        if (!hit_r && !full) begin
          filled_count <= filled_count + CW'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg    <= {key_handle, layer_count, round_radius(radius_q4)};
      rd_ptr     <= '0;
      hit_r      <= 1'b0;
      best_valid <= 1'b0;
    end
    if (cmd.scan) begin
      if (rd_more) begin
        rd_ptr   <= rd_ptr + CW'(1);
        pend_idx <= rd_ptr[AW-1:0];
      end
      if (status.match) begin
        hit_r   <= 1'b1;
        hit_idx <= pend_idx;
      end
      if (pend && (!best_valid || (rd_stamp < best_stamp))) begin
        best_valid <= 1'b1;
        best_idx   <= pend_idx;
        best_stamp <= rd_stamp;
      end
    end
    if (cmd.update) begin
      hit     <= hit_r;
      slot    <= SLOT_W'(pick);
      evicted <= !hit_r && full;
    end
  end

endmodule
